/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the escape-time pixel unit.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* rtl/ment_pkg.sv */
// Types, constants and helpers for the escape-time pixel unit.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
package ment_pkg;

  localparam int COORD_BITS     = 11;
  localparam int MAX_ITERATIONS = 32;
  localparam int CELL_COUNT     = MAX_ITERATIONS + 1;
  localparam int LIMIT_W        = $clog2(MAX_ITERATIONS + 1);
  localparam int CFG_LIMIT_W    = 6;
  localparam int Q_W            = 32;
  localparam int FRAC_BITS      = 28;
  localparam int SAT_W          = 48;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_INDEX_W    = 3;

  localparam logic [31:0] COLOR_ESCAPED = 32'hFFFF_00FF;
  localparam logic [31:0] COLOR_BOUNDED = 32'hFFFF_FFFF;
  // |z|^2 > 4 in Q8.56
  localparam logic [63:0] ESCAPE_BOUND  = 64'h0400_0000_0000_0000;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-64'sd2147483648);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ITERATION_LIMIT = 3'd0,
    REG_REAL_ORIGIN     = 3'd1,
    REG_REAL_STEP       = 3'd2,
    REG_IMAG_ORIGIN     = 3'd3,
    REG_IMAG_STEP       = 3'd4
  } ment_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } ment_pixel_t;

  typedef struct packed {
    logic        escaped;
    logic [5:0]  iterations_used;
    logic [31:0] pixel_color;
  } ment_result_t;

  typedef struct packed {
    logic [CFG_LIMIT_W-1:0] iteration_limit;
    logic signed [Q_W-1:0]  real_origin;
    logic signed [Q_W-1:0]  real_step;
    logic signed [Q_W-1:0]  imag_origin;
    logic signed [Q_W-1:0]  imag_step;
  } ment_cfg_t;

  // State of one point as it travels down the cell chain
  typedef struct packed {
    logic signed [Q_W-1:0] c_re;
    logic signed [Q_W-1:0] c_im;
    logic signed [Q_W-1:0] z_re;
    logic signed [Q_W-1:0] z_im;
    logic [LIMIT_W-1:0]    limit;
    logic [LIMIT_W-1:0]    used;
    logic                  done;
    logic                  escaped;
  } ment_item_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[Q_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/ment_ifs.sv */
// Valid/ready channel interfaces for pixel requests and results.
// Depends on ment_pkg for the payload types.
interface ment_pixel_if import ment_pkg::*;;
  logic        valid;
  logic        ready;
  ment_pixel_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ment_result_if import ment_pkg::*;;
  logic         valid;
  logic         ready;
  ment_result_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/ment_map.sv */
// Two-stage mapping of a pixel coordinate to the complex point c.
// Depends on ment_pkg.
module ment_map import ment_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  ment_pixel_t pixel,
  input  ment_cfg_t   cfg,
  output logic        out_valid,
  output ment_item_t  item
);

  logic                         prod_valid;
  logic signed [COORD_BITS+Q_W:0] prod_re;
  logic signed [COORD_BITS+Q_W:0] prod_im;
  logic [LIMIT_W-1:0]           limit;
  logic [LIMIT_W-1:0]           limit_next;
  logic signed [SAT_W-1:0]      sum_re;
  logic signed [SAT_W-1:0]      sum_im;

  always_comb begin
    if (cfg.iteration_limit > CFG_LIMIT_W'(MAX_ITERATIONS)) begin
      limit_next = LIMIT_W'(MAX_ITERATIONS);
    end else begin
      limit_next = LIMIT_W'(cfg.iteration_limit);
    end
  end

  assign sum_re = SAT_W'(prod_re) + SAT_W'(cfg.real_origin);
  assign sum_im = SAT_W'(prod_im) + SAT_W'(cfg.imag_origin);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_re      <= $signed({1'b0, pixel.pixel_x}) * cfg.real_step;
      prod_im      <= $signed({1'b0, pixel.pixel_y}) * cfg.imag_step;
      limit        <= limit_next;
      item.c_re    <= sat_q(sum_re);
      item.c_im    <= sat_q(sum_im);
      item.z_re    <= '0;
      item.z_im    <= '0;
      item.limit   <= limit;
      item.used    <= '0;
      item.done    <= 1'b0;
      item.escaped <= 1'b0;
    end
  end

endmodule

/* rtl/ment_cell.sv */
// One iteration cell: squares z, tests for escape, applies z = z*z + c.
// Two register stages; depends on ment_pkg.
module ment_cell import ment_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  ment_item_t in_item,
  output logic       out_valid,
  output ment_item_t out_item
);

  logic              a_valid;
  ment_item_t        a_item;
  logic signed [63:0] rr;
  logic signed [63:0] ii;
  logic signed [63:0] ri;
  logic [63:0]        mag;
  logic signed [63:0] diff;
  logic signed [63:0] re_sh;
  logic signed [63:0] im_sh;
  logic signed [SAT_W-1:0] re_sum;
  logic signed [SAT_W-1:0] im_sum;
  ment_item_t        out_item_next;

  assign mag    = $unsigned(rr) + $unsigned(ii);
  assign diff   = rr - ii;
  assign re_sh  = diff >>> FRAC_BITS;
  assign im_sh  = ri >>> (FRAC_BITS - 1);
  assign re_sum = SAT_W'(re_sh) + SAT_W'(a_item.c_re);
  assign im_sum = SAT_W'(im_sh) + SAT_W'(a_item.c_im);

  // The squares of the incoming z double as the escape test of the previous iteration
  always_comb begin
    out_item_next = a_item;
    if (!a_item.done) begin
      if (mag > ESCAPE_BOUND) begin
        out_item_next.done    = 1'b1;
        out_item_next.escaped = 1'b1;
      end else if (a_item.used == a_item.limit) begin
        out_item_next.done = 1'b1;
      end else begin
        out_item_next.z_re = sat_q(re_sum);
        out_item_next.z_im = sat_q(im_sum);
        out_item_next.used = a_item.used + LIMIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item   <= in_item;
      rr       <= in_item.z_re * in_item.z_re;
      ii       <= in_item.z_im * in_item.z_im;
      ri       <= in_item.z_re * in_item.z_im;
      out_item <= out_item_next;
    end
  end

endmodule

/* rtl/ment_obuf.sv */
// Output register with a skid entry; formats the finished point as a result.
// Depends on ment_pkg, ment_ifs and assert_macros.svh.
`include "assert_macros.svh"

module ment_obuf import ment_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  ment_item_t in_item,
  output logic       en,
  ment_result_if.source results
);

  logic         out_valid;
  ment_result_t out_data;
  logic         skid_valid;
  ment_result_t skid_data;
  ment_result_t fmt;
  logic         take;
  logic         in_fire;

  assign fmt.escaped         = in_item.escaped;
  assign fmt.iterations_used = 6'(in_item.used);
  assign fmt.pixel_color     = in_item.escaped ? COLOR_ESCAPED : COLOR_BOUNDED;

  // Chain advances whenever the skid entry is free
  assign en      = !skid_valid;
  assign take    = out_valid && results.ready;
  assign in_fire = in_valid && en;

  assign results.valid = out_valid;
  assign results.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid || take) begin
        out_data <= fmt;
      end else begin
        skid_data <= fmt;
      end
    end else if (take && skid_valid) begin
      out_data <= skid_data;
    end
  end

  `ASSERT_NEVER(a_skid_without_out, skid_valid && !out_valid, "skid holds a result behind an empty output")
  `ASSERT_CLK(a_skid_refills, (take && skid_valid) |=> out_valid, "skid result lost on take")
  `ASSERT_NEVER(a_escape_at_zero, out_valid && out_data.escaped && (out_data.iterations_used == 6'd0), "escape reported with no iteration")

endmodule

/* rtl/mandelbrot_escape_time_pixel_unit.sv */
// Escape-time pixel unit: maps a pixel to c and runs z = z*z + c down a chain of cells.
// Throughput one pixel per cycle while the skid entry is free, set by the 33 two-stage
// iteration cells that each take a new point every cycle; a full skid entry stalls them.
// Results drain through an output register plus one skid entry, which sets the ready path.
// Synchronous active-high reset clears all valid bits and loads the default view
// (limit 5, origin -2.5 + 1.5i); no clearing pass is needed.
module mandelbrot_escape_time_pixel_unit import ment_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ment_pixel_if.sink             pixels,
  ment_result_if.source          results
);

  ment_cfg_t  cfg;
  logic       en;
  logic       chain_valid [CELL_COUNT+1];
  ment_item_t chain_item  [CELL_COUNT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.iteration_limit <= CFG_LIMIT_W'(5);
      cfg.real_origin     <= -32'sd671088640;
      cfg.real_step       <= 32'sd994205;
      cfg.imag_origin     <= 32'sd402653184;
      cfg.imag_step       <= -32'sd947419;
    end else if (cfg_write) begin
      unique case (ment_reg_t'(cfg_index))
        REG_ITERATION_LIMIT: cfg.iteration_limit <= cfg_data[CFG_LIMIT_W-1:0];
        REG_REAL_ORIGIN:     cfg.real_origin     <= cfg_data;
        REG_REAL_STEP:       cfg.real_step       <= cfg_data;
        REG_IMAG_ORIGIN:     cfg.imag_origin     <= cfg_data;
        REG_IMAG_STEP:       cfg.imag_step       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pixels.ready = en;

  ment_map u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixels.valid),
    .pixel     (pixels.data),
    .cfg       (cfg),
    .out_valid (chain_valid[0]),
    .item      (chain_item[0])
  );

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    ment_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  ment_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_valid[CELL_COUNT]),
    .in_item  (chain_item[CELL_COUNT]),
    .en       (en),
    .results  (results)
  );

endmodule
